### design/hvs_pkg.sv
package hvs_pkg;

  localparam int MAX_STATES      = 4;
  localparam int MAX_SYMBOLS     = 3;
  localparam int DEF_NUM_STATES  = 4;
  localparam int DEF_NUM_SYMBOLS = 3;
  localparam int PW              = 16;
  localparam int REG_W           = 64;
  localparam int IDX_W           = 3;
  localparam logic [PW-1:0] ONE_Q15 = 16'h8000;

  localparam logic [IDX_W-1:0] REG_TRANS0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRANS1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_TRANS2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_EMIT0  = 3'd4;
  localparam logic [IDX_W-1:0] REG_EMIT1  = 3'd5;
  localparam logic [IDX_W-1:0] REG_EMIT2  = 3'd6;
  localparam logic [IDX_W-1:0] REG_PRIOR  = 3'd7;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // capture input item
    logic       prod;      // compute product for state i, pred j (prior times emission on a first item)
    logic       emul;      // multiply running max of state i by emission
    logic       div_start; // start divide for state i
    logic       div_step;  // one quotient bit
    logic       div_store; // store quotient of state i
    logic       finish;    // compute best, drive output
    logic [1:0] i;
    logic [1:0] j;
  } hvs_cmd_t;

  typedef struct packed {
    logic first;
    logic no_path;
  } hvs_sts_t;

  function automatic logic [PW-1:0] sat_lane(logic [REG_W-1:0] r, logic [1:0] k);
    logic [PW-1:0] v;
    v = r[16*k +: 16];
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

### design/hmm_viterbi_step.sv
// One scaled Viterbi step of a four-state HMM in Q1.15. A later item runs
// the product sweep (one shared 16x16 multiply a cycle: sixteen
// state/predecessor products and four emission products) and then, state by
// state, the restoring divider that scales the scores; a first item does
// the four prior products and skips the divider, and a zero sum, checked at
// the divider's start, skips it as well. One item
// is in flight at a time, and the result is held until taken.
module hmm_viterbi_step
  import hvs_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_first,
  input  logic [1:0]       in_symbol,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PW-1:0]    out_score_0,
  output logic [PW-1:0]    out_score_1,
  output logic [PW-1:0]    out_score_2,
  output logic [PW-1:0]    out_score_3,
  output logic [1:0]       out_back_0,
  output logic [1:0]       out_back_1,
  output logic [1:0]       out_back_2,
  output logic [1:0]       out_back_3,
  output logic [1:0]       out_best_state,
  output logic [1:0]       out_best_predecessor,
  output logic             out_no_path
);

  hvs_cmd_t cmd;
  hvs_sts_t sts;

  hvs_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  hvs_dpath #(.NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_first, .in_symbol,
    .cmd, .sts, .out_score_0, .out_score_1, .out_score_2, .out_score_3,
    .out_back_0, .out_back_1, .out_back_2, .out_back_3, .out_best_state,
    .out_best_predecessor, .out_no_path
  );

endmodule

### design/hvs_ctrl.sv
module hvs_ctrl
  import hvs_pkg::*;
#(
  parameter int NUM_STATES = DEF_NUM_STATES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  hvs_sts_t sts,
  output hvs_cmd_t cmd
);

  localparam logic [1:0] LAST = 2'(NUM_STATES - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROD = 6'b000010,
    S_EMUL = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t     st_r, st_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic [4:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      i_r  <= '0;
      j_r  <= '0;
      k_r  <= '0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      j_r  <= j_nxt;
      k_r  <= k_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    j_nxt  = j_r;
    k_nxt  = k_r;
    cmd    = '0;
    cmd.i  = i_r;
    cmd.j  = j_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          i_nxt = '0;
          j_nxt = '0;
          st_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        if (sts.first) begin
          if (i_r == LAST) begin
            i_nxt = '0;
            st_nxt = S_FIN;
          end else begin
            i_nxt = i_r + 2'd1;
          end
        end else if (j_r == LAST) begin
          j_nxt = '0;
          st_nxt = S_EMUL;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      S_EMUL: begin
        cmd.emul = 1'b1;
        if (i_r == LAST) begin
          i_nxt = '0;
          k_nxt = '0;
          st_nxt = S_DIV;
        end else begin
          i_nxt = i_r + 2'd1;
          st_nxt = S_PROD;
        end
      end
      S_DIV: begin
        if (k_r == 5'd0) begin
          if (sts.no_path) begin
            st_nxt = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            k_nxt = 5'd1;
          end
        end else if (k_r == 5'd16) begin
          cmd.div_store = 1'b1;
          k_nxt = '0;
          if (i_r == LAST) st_nxt = S_FIN;
          else i_nxt = i_r + 2'd1;
        end else begin
          cmd.div_step = 1'b1;
          k_nxt = k_r + 5'd1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

### design/hvs_dpath.sv
module hvs_dpath
  import hvs_pkg::*;
#(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             in_first,
  input  logic [1:0]       in_symbol,
  input  hvs_cmd_t         cmd,
  output hvs_sts_t         sts,
  output logic [PW-1:0]    out_score_0,
  output logic [PW-1:0]    out_score_1,
  output logic [PW-1:0]    out_score_2,
  output logic [PW-1:0]    out_score_3,
  output logic [1:0]       out_back_0,
  output logic [1:0]       out_back_1,
  output logic [1:0]       out_back_2,
  output logic [1:0]       out_back_3,
  output logic [1:0]       out_best_state,
  output logic [1:0]       out_best_predecessor,
  output logic             out_no_path
);

  logic [REG_W-1:0] trans_r [MAX_STATES];
  logic [REG_W-1:0] emit_r  [MAX_SYMBOLS];
  logic [REG_W-1:0] prior_r;
  logic [PW-1:0]    prev_r  [MAX_STATES];
  logic [PW-1:0]    v_r     [MAX_STATES];
  logic [1:0]       back_r  [MAX_STATES];
  logic [PW-1:0]    m_r;
  logic [17:0]      sum_r;
  logic             first_r;
  logic [1:0]       sym_r;
  logic [17:0]      rem_r;
  logic [15:0]      quo_r;
  logic [1:0]       best_r;
  logic             nopath_r;

  logic [PW-1:0] emis, mul_a, mul_b, prod;
  logic [31:0]   full;
  logic [18:0]   trial;
  logic [17:0]   sum_nxt;
  logic [1:0]    best;

  always_comb begin
    emis = (sym_r < 2'(NUM_SYMBOLS) && sym_r != 2'd3) ? sat_lane(emit_r[sym_r], cmd.i) : '0;
    if (cmd.emul) begin
      mul_a = m_r;
      mul_b = emis;
    end else if (first_r) begin
      mul_a = sat_lane(prior_r, cmd.i);
      mul_b = emis;
    end else begin
      mul_a = prev_r[cmd.j];
      mul_b = sat_lane(trans_r[cmd.j], cmd.i);
    end
    full = 32'(mul_a) * 32'(mul_b);
    prod = full[30:15];
    trial = {rem_r, 1'b0} - {1'b0, sum_r};
  end

  // running max over predecessors of state i
  logic [PW-1:0] mx;
  logic [1:0]    ag;
  always_comb begin
    mx = m_r;
    ag = back_r[cmd.i];
    if (cmd.j == 2'd0 || prod > m_r) begin
      mx = prod;
      ag = cmd.j;
    end
  end

  assign sum_nxt = sum_r + 18'(prod);

  always_comb begin
    best = '0;
    for (int s = 1; s < NUM_STATES; s++)
      if (v_r[s] > v_r[best]) best = 2'(s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_STATES; s++) begin
        trans_r[s] <= '0;
        prev_r[s]  <= '0;
      end
      for (int s = 0; s < MAX_SYMBOLS; s++) emit_r[s] <= '0;
      prior_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRANS0: trans_r[0] <= cfg_data;
          REG_TRANS1: trans_r[1] <= cfg_data;
          REG_TRANS2: trans_r[2] <= cfg_data;
          REG_TRANS3: trans_r[3] <= cfg_data;
          REG_EMIT0:  emit_r[0]  <= cfg_data;
          REG_EMIT1:  emit_r[1]  <= cfg_data;
          REG_EMIT2:  emit_r[2]  <= cfg_data;
          REG_PRIOR:  prior_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish)
        for (int s = 0; s < MAX_STATES; s++) prev_r[s] <= v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_first;
      sym_r   <= in_symbol;
      sum_r   <= '0;
      m_r     <= '0;
      for (int s = 0; s < MAX_STATES; s++) begin
        v_r[s]    <= '0;
        back_r[s] <= '0;
      end
    end
    if (cmd.prod) begin
      if (first_r) begin
        v_r[cmd.i] <= prod;
        sum_r      <= sum_nxt;
      end else begin
        m_r           <= mx;
        back_r[cmd.i] <= ag;
      end
    end
    if (cmd.emul) begin
      v_r[cmd.i] <= prod;
      sum_r      <= sum_nxt;
    end
    if (cmd.div_start) begin
      rem_r <= 18'(v_r[cmd.i]);
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[18]) begin
        rem_r <= trial[17:0];
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= {rem_r[16:0], 1'b0};
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      // quotient = floor(v*32768/sum), at most 32768
      if (18'(v_r[cmd.i]) == sum_r) v_r[cmd.i] <= ONE_Q15;
      else v_r[cmd.i] <= quo_r;
    end
    if (cmd.finish) begin
      if (!first_r && sum_r == '0)
        for (int s = 0; s < MAX_STATES; s++) v_r[s] <= '0;
      best_r   <= best;
      nopath_r <= (sum_r == '0);
    end
  end

  assign sts.first   = first_r;
  assign sts.no_path = (sum_r == '0);

  assign out_score_0 = v_r[0];
  assign out_score_1 = v_r[1];
  assign out_score_2 = v_r[2];
  assign out_score_3 = v_r[3];
  assign out_back_0  = back_r[0];
  assign out_back_1  = back_r[1];
  assign out_back_2  = back_r[2];
  assign out_back_3  = back_r[3];
  assign out_best_state       = best_r;
  assign out_best_predecessor = back_r[best_r];
  assign out_no_path          = nopath_r;

  logic unused;
  assign unused = ^{full[31], full[14:0], rst_n};

endmodule

### design/hvs_checker.sv
module hvs_checker
  import hvs_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [PW-1:0] out_score_0,
  input logic          out_no_path
);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score_0))
    else $error("result dropped");

  a_nopath: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_path |-> out_score_0 == '0) else $error("score on no path");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");

endmodule

bind hmm_viterbi_step hvs_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_score_0, .out_no_path
);
